// ----- sv/escaped_packet_deframer_assert.svh -----
// assertion macros used by the checker file
`ifndef ESCAPED_PACKET_DEFRAMER_ASSERT_SVH
`define ESCAPED_PACKET_DEFRAMER_ASSERT_SVH

// condition holds at every edge outside reset
`define EPD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("deframer check failed");

// antecedent at one edge implies consequent at the next edge
`define EPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer sequence check failed");

`endif

// ----- sv/epd_pkg.sv -----
package epd_pkg;

  // payload store depth, 1 to 62
  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  localparam int COUNT_W = 6;

  localparam logic [7:0] OPEN_BYTE   = 8'h7B;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7C;
  localparam logic [7:0] CLOSE_BYTE  = 8'h7D;
  localparam logic [7:0] ESCAPE_XOR  = 8'h20;

  typedef logic [7:0]         byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;

endpackage

// ----- sv/escaped_packet_deframer.sv -----
// channel   direction  handshake                  payload
// raw       into       raw_valid / raw_stall      raw_byte
// result    out of     result_valid / result_stall is_header, command_code,
//                                                 payload_length, payload_byte, last_item
//
// one received byte is taken per cycle while no frame is draining
// a good close stalls raw for the drain: the header loads once the output
// register is free, then each payload byte takes a store read, then a load
// the payload store is a synchronous memory with a registered read
// rst is synchronous and clears framing, drain and output valid state
// the payload store has no reset; only entries written in the frame are read
module escaped_packet_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       raw_valid,
  output logic       raw_stall,
  input  logic [7:0] raw_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       is_header,
  output logic [7:0] command_code,
  output logic [5:0] payload_length,
  output logic [7:0] payload_byte,
  output logic       last_item
);

  // drain sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;  // taking raw bytes
  localparam logic [1:0] ST_HDR  = 2'd1;  // header waiting for output register
  localparam logic [1:0] ST_RD   = 2'd2;  // issue store read
  localparam logic [1:0] ST_LD   = 2'd3;  // read data into output register

  logic [1:0] state, state_next;

  // framing state
  logic            escape_pending, escape_pending_next;
  logic            in_frame, in_frame_next;
  epd_pkg::count_t frame_byte_count, frame_byte_count_next;
  epd_pkg::byte_t  held_command, held_command_next;

  // drain bookkeeping
  epd_pkg::count_t len, len_next;
  epd_pkg::count_t rd_idx, rd_idx_next;

  // payload store
  epd_pkg::byte_t payload_store [epd_pkg::PAYLOAD_DEPTH];
  logic           wr_en;
  epd_pkg::addr_t wr_addr;
  epd_pkg::byte_t wr_data;
  logic           rd_en;
  epd_pkg::byte_t rd_data;

  logic raw_take, result_take, out_free;
  logic is_data;
  epd_pkg::byte_t data_byte;
  epd_pkg::count_t count_m1;
  logic load_hdr, load_pay, pay_last;

  assign raw_stall   = (state != ST_IDLE);
  assign raw_take    = raw_valid && !raw_stall;
  assign result_take = result_valid && !result_stall;
  // output register empty next cycle unless reloaded
  assign out_free    = !result_valid || result_take;
  assign count_m1    = frame_byte_count - epd_pkg::count_t'(1);
  assign pay_last    = ((rd_idx + epd_pkg::count_t'(1)) == len);

  always_comb begin
    escape_pending_next   = escape_pending;
    in_frame_next         = in_frame;
    frame_byte_count_next = frame_byte_count;
    held_command_next     = held_command;
    len_next              = len;
    rd_idx_next           = rd_idx;
    state_next            = state;
    is_data               = 1'b0;
    data_byte             = raw_byte;
    wr_en                 = 1'b0;
    wr_addr               = count_m1[epd_pkg::ADDR_W-1:0];
    wr_data               = data_byte;
    rd_en                 = 1'b0;
    load_hdr              = 1'b0;
    load_pay              = 1'b0;

    case (state)
      ST_IDLE: begin
        if (raw_take) begin
          if (escape_pending) begin
            // escaped byte is data whatever its value
            escape_pending_next = 1'b0;
            is_data   = 1'b1;
            data_byte = raw_byte ^ epd_pkg::ESCAPE_XOR;
          end else if (raw_byte == epd_pkg::ESCAPE_BYTE) begin
            escape_pending_next = 1'b1;
          end else if (raw_byte == epd_pkg::OPEN_BYTE) begin
            // open, or restart of an open frame
            in_frame_next         = 1'b1;
            frame_byte_count_next = '0;
          end else if (raw_byte != epd_pkg::CLOSE_BYTE) begin
            is_data = 1'b1;
          end else if (in_frame) begin
            in_frame_next = 1'b0;
            // close with no command byte is dropped
            if (frame_byte_count != '0) begin
              if (count_m1 > epd_pkg::count_t'(epd_pkg::PAYLOAD_DEPTH)) begin
                len_next = epd_pkg::count_t'(epd_pkg::PAYLOAD_DEPTH);
              end else begin
                len_next = count_m1;
              end
              state_next = ST_HDR;
            end
          end

          if (is_data && in_frame) begin
            wr_data = data_byte;
            if (frame_byte_count == '0) begin
              held_command_next = data_byte;
            end else if (count_m1 < epd_pkg::count_t'(epd_pkg::PAYLOAD_DEPTH)) begin
              wr_en = 1'b1;
            end else begin
              // payload overflow drops the frame
              in_frame_next = 1'b0;
            end
            frame_byte_count_next = frame_byte_count + epd_pkg::count_t'(1);
          end
        end
      end
      ST_HDR: begin
        if (out_free) begin
          load_hdr    = 1'b1;
          rd_idx_next = '0;
          state_next  = (len == '0) ? ST_IDLE : ST_RD;
        end
      end
      ST_RD: begin
        if (out_free) begin
          rd_en      = 1'b1;
          state_next = ST_LD;
        end
      end
      ST_LD: begin
        // output register is empty here: it was freed when the read issued
        load_pay    = 1'b1;
        rd_idx_next = rd_idx + epd_pkg::count_t'(1);
        state_next  = pay_last ? ST_IDLE : ST_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // payload store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= payload_store[rd_idx[epd_pkg::ADDR_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      escape_pending   <= 1'b0;
      in_frame         <= 1'b0;
      frame_byte_count <= '0;
      held_command     <= '0;
      len              <= '0;
      rd_idx           <= '0;
    end else begin
      state            <= state_next;
      escape_pending   <= escape_pending_next;
      in_frame         <= in_frame_next;
      frame_byte_count <= frame_byte_count_next;
      held_command     <= held_command_next;
      len              <= len_next;
      rd_idx           <= rd_idx_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_hdr || load_pay) begin
      result_valid <= 1'b1;
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hdr) begin
      is_header      <= 1'b1;
      command_code   <= held_command;
      payload_length <= len;
      payload_byte   <= '0;
      last_item      <= (len == '0);
    end else if (load_pay) begin
      is_header      <= 1'b0;
      command_code   <= held_command;
      payload_length <= len;
      payload_byte   <= rd_data;
      last_item      <= pay_last;
    end
  end

endmodule

// ----- sv/epd_checker.sv -----
`include "escaped_packet_deframer_assert.svh"

module epd_checker (
  input logic       clk,
  input logic       rst,
  input logic       raw_valid,
  input logic       raw_stall,
  input logic [7:0] raw_byte,
  input logic       result_valid,
  input logic       result_stall,
  input logic       is_header,
  input logic [5:0] payload_length,
  input logic [7:0] payload_byte,
  input logic       last_item
);

  logic result_take;
  assign result_take = result_valid && !result_stall;

  // length never exceeds the store
  `EPD_ASSERT_ALWAYS(a_len_bound,
    !result_valid || (payload_length <= 6'(epd_pkg::PAYLOAD_DEPTH)))

  // header is last exactly when the payload is empty, and carries no byte
  `EPD_ASSERT_ALWAYS(a_hdr_fields,
    !(result_valid && is_header) ||
    ((last_item == (payload_length == 6'd0)) && (payload_byte == 8'd0)))

  // raw side stays stalled while a frame is still draining
  `EPD_ASSERT_NEXT(a_drain_stall, result_take && !last_item, raw_stall)

  // empty-payload header never shows as a payload item
  `EPD_ASSERT_ALWAYS(a_pay_len,
    !(result_valid && !is_header) || (payload_length != 6'd0))

  // raw side never waits on a channel that holds no drain
  `EPD_ASSERT_NEXT(a_idle_free,
    !raw_stall && !(raw_valid && (raw_byte == epd_pkg::CLOSE_BYTE)), !raw_stall)

endmodule

bind escaped_packet_deframer epd_checker u_epd_checker (.*);
